// ----- hdl/bmsi_pkg.sv -----
// Package for the banked mapper with scanline IRQ.
// Holds the transaction structs, request kinds and register decode constants.
// No dependencies.
package bmsi_pkg;

    typedef enum logic [2:0] {
        REQ_WRITE = 3'd0,
        REQ_TICK  = 3'd1,
        REQ_PPU   = 3'd2,
        REQ_PRG   = 3'd3,
        REQ_CHR   = 3'd4
    } req_kind_t;

    localparam logic [15:0] WR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] WR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] WR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] WR_MIRROR      = 16'hA000;
    localparam logic [15:0] WR_RELOAD      = 16'hC000;
    localparam logic [15:0] WR_IRQ_MODE    = 16'hC001;
    localparam logic [15:0] WR_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] WR_IRQ_ENABLE  = 16'hE001;

    localparam logic [3:0] A12_FILTER     = 4'd10;
    localparam logic [3:0] A12_TICKS_MAX  = 4'd15;
    localparam logic [7:0] PRG_LAST_BANK  = 8'd255;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  value;
    } req_t;

    typedef struct packed {
        logic [8:0] bank;
        logic       irq_line;
        logic       mirror_horizontal;
    } rsp_t;

endpackage

// ----- hdl/banked_mapper_with_scanline_irq.sv -----
// Top level of the banked mapper with scanline IRQ.
// Depends on bmsi_pkg for the transaction structs and decode constants.
//
//   channel | direction | payload            | handshake
//   req     | in        | bmsi_pkg::req_t    | req_valid / req_ready
//   rsp     | out       | bmsi_pkg::rsp_t    | rsp_valid / rsp_ready
//
// Every request transaction yields one response transaction through the read stage
// and the response register. A new one is taken every cycle while req_ready is high;
// the bank memory is read on acceptance and combined into the response register.
// Reset clears all control state and the bank memory valid bits at once; no sweep.
// When the response is stalled, one further transaction is held in the read stage
// and then req_ready falls.
module banked_mapper_with_scanline_irq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  bmsi_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bmsi_pkg::rsp_t  rsp
);

    typedef struct packed {
        logic       lookup;
        logic       fixed_last;
        logic       plus_one;
        logic       irq_line;
        logic       mirror;
    } stage_t;

    logic [7:0]  bank_mem [16];
    logic [15:0] mem_valid_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_valid_reg;

    logic [7:0]  bank_select_reg, bank_select_next;
    logic        mirror_reg, mirror_next;
    logic [7:0]  reload_reg, reload_next;
    logic [8:0]  count_reg, count_next;
    logic        pending_reg, pending_next;
    logic        enable_reg, enable_next;
    logic        cycle_mode_reg, cycle_mode_next;
    logic [1:0]  prescaler_reg, prescaler_next;
    logic        force_reg, force_next;
    logic [1:0]  wait_reg, wait_next;
    logic        level_reg, level_next;
    logic        low_seen_reg, low_seen_next;
    logic [3:0]  low_ticks_reg, low_ticks_next;

    logic        s1_valid_reg;
    stage_t      s1_reg, s1_next;
    logic        out_valid_reg;
    bmsi_pkg::rsp_t out_reg;

    logic        req_fire;
    logic        s1_move;
    logic        mem_we;
    logic [3:0]  mem_raddr;
    logic        clk_cnt;
    logic [1:0]  clk_wait;
    logic [8:0]  cnt_base;
    logic [8:0]  cnt_dec;
    logic        a12_edge;
    logic [2:0]  chr_slot;
    logic [7:0]  rd_byte;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_move;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        bank_select_next = bank_select_reg;
        mirror_next      = mirror_reg;
        reload_next      = reload_reg;
        count_next       = count_reg;
        pending_next     = pending_reg;
        enable_next      = enable_reg;
        cycle_mode_next  = cycle_mode_reg;
        prescaler_next   = prescaler_reg;
        force_next       = force_reg;
        wait_next        = wait_reg;
        level_next       = level_reg;
        low_seen_next    = low_seen_reg;
        low_ticks_next   = low_ticks_reg;
        mem_we           = 1'b0;
        clk_cnt          = 1'b0;
        clk_wait         = 2'd1;
        a12_edge         = 1'b0;
        cnt_base         = count_reg;
        cnt_dec          = count_reg;
        mem_raddr        = 4'd0;
        chr_slot         = req.addr[12:10] ^ {bank_select_reg[7], 2'b00};
        s1_next          = '0;

        case (req.req_type)
            bmsi_pkg::REQ_WRITE:
            begin
                case (req.addr & bmsi_pkg::WR_DECODE_MASK)
                    bmsi_pkg::WR_BANK_SELECT: bank_select_next = req.value;
                    bmsi_pkg::WR_BANK_DATA:   mem_we = 1'b1;
                    bmsi_pkg::WR_MIRROR:      mirror_next = req.value[0];
                    bmsi_pkg::WR_RELOAD:      reload_next = req.value;
                    bmsi_pkg::WR_IRQ_MODE:
                    begin
                        if (cycle_mode_reg && !req.value[0])
                        begin
                            force_next = 1'b1;
                        end
                        cycle_mode_next = req.value[0];
                        if (req.value[0])
                        begin
                            prescaler_next = 2'd0;
                        end
                        pending_next = 1'b1;
                    end
                    bmsi_pkg::WR_IRQ_DISABLE:
                    begin
                        enable_next = 1'b0;
                        level_next  = 1'b0;
                    end
                    bmsi_pkg::WR_IRQ_ENABLE:  enable_next = 1'b1;
                    default: ;
                endcase
            end
            bmsi_pkg::REQ_TICK:
            begin
                if (wait_reg != 2'd0)
                begin
                    wait_next = wait_reg - 2'd1;
                    if (wait_reg == 2'd1)
                    begin
                        level_next = 1'b1;
                    end
                end
                if (low_seen_reg && low_ticks_reg != bmsi_pkg::A12_TICKS_MAX)
                begin
                    low_ticks_next = low_ticks_reg + 4'd1;
                end
                if (cycle_mode_reg || force_reg)
                begin
                    prescaler_next = prescaler_reg + 2'd1;
                    if (prescaler_reg == 2'd3)
                    begin
                        clk_cnt    = 1'b1;
                        clk_wait   = 2'd1;
                        force_next = 1'b0;
                    end
                end
            end
            bmsi_pkg::REQ_PPU:
            begin
                if (!cycle_mode_reg)
                begin
                    if (req.addr[12])
                    begin
                        a12_edge       = low_seen_reg && (low_ticks_reg >= bmsi_pkg::A12_FILTER);
                        low_seen_next  = 1'b0;
                        low_ticks_next = 4'd0;
                        clk_cnt        = a12_edge;
                        clk_wait       = 2'd2;
                    end
                    else if (!low_seen_reg)
                    begin
                        low_seen_next  = 1'b1;
                        low_ticks_next = 4'd0;
                    end
                end
            end
            bmsi_pkg::REQ_PRG:
            begin
                s1_next.lookup = 1'b1;
                case (req.addr[14:13])
                    2'd0:    mem_raddr = bank_select_reg[6] ? 4'd15 : 4'd6;
                    2'd1:    mem_raddr = bank_select_reg[6] ? 4'd6 : 4'd7;
                    2'd2:    mem_raddr = bank_select_reg[6] ? 4'd7 : 4'd15;
                    default: s1_next.fixed_last = 1'b1;
                endcase
            end
            bmsi_pkg::REQ_CHR:
            begin
                s1_next.lookup = 1'b1;
                case (chr_slot)
                    3'd0: mem_raddr = 4'd0;
                    3'd1:
                    begin
                        mem_raddr        = bank_select_reg[5] ? 4'd8 : 4'd0;
                        s1_next.plus_one = !bank_select_reg[5];
                    end
                    3'd2: mem_raddr = 4'd1;
                    3'd3:
                    begin
                        mem_raddr        = bank_select_reg[5] ? 4'd9 : 4'd1;
                        s1_next.plus_one = !bank_select_reg[5];
                    end
                    3'd4: mem_raddr = 4'd2;
                    3'd5: mem_raddr = 4'd3;
                    3'd6: mem_raddr = 4'd4;
                    default: mem_raddr = 4'd5;
                endcase
            end
            default: ;
        endcase

        if (clk_cnt)
        begin
            if (pending_reg)
            begin
                cnt_base     = (reload_reg <= 8'd1) ? ({1'b0, reload_reg} + 9'd1)
                                                    : ({1'b0, reload_reg} + 9'd2);
                pending_next = 1'b0;
            end
            else if (count_reg == 9'd0)
            begin
                cnt_base = {1'b0, reload_reg} + 9'd1;
            end
            cnt_dec    = cnt_base - 9'd1;
            count_next = cnt_dec;
            if (cnt_dec == 9'd0 && enable_reg)
            begin
                wait_next = clk_wait;
            end
        end

        s1_next.irq_line = level_next;
        s1_next.mirror   = mirror_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && mem_we)
        begin
            bank_mem[bank_select_reg[3:0]] <= req.value;
        end
        if (req_fire)
        begin
            rd_data_reg <= bank_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else if (req_fire)
        begin
            rd_valid_reg <= mem_valid_reg[mem_raddr];
            if (mem_we)
            begin
                mem_valid_reg[bank_select_reg[3:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= '0;
            mirror_reg      <= 1'b0;
            reload_reg      <= '0;
            count_reg       <= '0;
            pending_reg     <= 1'b0;
            enable_reg      <= 1'b0;
            cycle_mode_reg  <= 1'b0;
            prescaler_reg   <= '0;
            force_reg       <= 1'b0;
            wait_reg        <= '0;
            level_reg       <= 1'b0;
            low_seen_reg    <= 1'b0;
            low_ticks_reg   <= '0;
        end
        else if (req_fire)
        begin
            bank_select_reg <= bank_select_next;
            mirror_reg      <= mirror_next;
            reload_reg      <= reload_next;
            count_reg       <= count_next;
            pending_reg     <= pending_next;
            enable_reg      <= enable_next;
            cycle_mode_reg  <= cycle_mode_next;
            prescaler_reg   <= prescaler_next;
            force_reg       <= force_next;
            wait_reg        <= wait_next;
            level_reg       <= level_next;
            low_seen_reg    <= low_seen_next;
            low_ticks_reg   <= low_ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rd_byte = rd_valid_reg ? rd_data_reg : 8'd0;

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            if (!s1_reg.lookup)
            begin
                out_reg.bank <= 9'd0;
            end
            else if (s1_reg.fixed_last)
            begin
                out_reg.bank <= {1'b0, bmsi_pkg::PRG_LAST_BANK};
            end
            else
            begin
                out_reg.bank <= {1'b0, rd_byte} + {8'd0, s1_reg.plus_one};
            end
            out_reg.irq_line          <= s1_reg.irq_line;
            out_reg.mirror_horizontal <= s1_reg.mirror;
        end
    end

endmodule

// ----- hdl/bmsi_checker.sv -----
// Port-level checker for the banked mapper with scanline IRQ, and its bind.
// Depends on bmsi_pkg and on the top level banked_mapper_with_scanline_irq.
module bmsi_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bmsi_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Stalled response transaction changed.");

    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("Response appeared without a request two cycles earlier.");

    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("Request side stalled while the response side was free.");

    a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.bank <= 9'd256)
        else $error("Bank number out of range.");

endmodule

bind banked_mapper_with_scanline_irq bmsi_checker u_bmsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/tb_banked_mapper_with_scanline_irq.sv -----
// Self-checking testbench for the banked mapper with scanline IRQ.
// Holds a scoreboard class that predicts each response and the top module that drives the block.
// Depends on bmsi_pkg and the RTL of banked_mapper_with_scanline_irq.

class mapper_scoreboard;
    bit [7:0] bank_sel;
    bit [7:0] bank_reg [16];
    bit       mirror;
    bit [7:0] reload;
    bit [8:0] irq_count;
    bit       reload_pend;
    bit       irq_en;
    bit       cycle_mode;
    bit [1:0] prescale;
    bit       force_tick;
    bit [1:0] irq_delay;
    bit       irq_level;
    bit       a12_low_seen;
    bit [3:0] a12_low_ticks;

    bmsi_pkg::rsp_t expected_rsp [$];
    int errors;
    int irq_seen;
    int kind_count [8];

    function void clock_counter(input bit [1:0] delay);
        if (reload_pend)
        begin
            irq_count = (reload <= 8'd1) ? {1'b0, reload} + 9'd1 : {1'b0, reload} + 9'd2;
            reload_pend = 1'b0;
        end
        else if (irq_count == 9'd0)
            irq_count = {1'b0, reload} + 9'd1;
        irq_count = irq_count - 9'd1;
        if (irq_count == 9'd0 && irq_en)
            irq_delay = delay;
    endfunction

    function void cpu_write(input logic [15:0] addr, input logic [7:0] value);
        case (addr & bmsi_pkg::WR_DECODE_MASK)
            bmsi_pkg::WR_BANK_SELECT: bank_sel = value;
            bmsi_pkg::WR_BANK_DATA:   bank_reg[bank_sel[3:0]] = value;
            bmsi_pkg::WR_MIRROR:      mirror = value[0];
            bmsi_pkg::WR_RELOAD:      reload = value;
            bmsi_pkg::WR_IRQ_MODE:
            begin
                if (cycle_mode && !value[0])
                    force_tick = 1'b1;
                cycle_mode = value[0];
                if (cycle_mode)
                    prescale = 2'd0;
                reload_pend = 1'b1;
            end
            bmsi_pkg::WR_IRQ_DISABLE:
            begin
                irq_en = 1'b0;
                irq_level = 1'b0;
            end
            bmsi_pkg::WR_IRQ_ENABLE:  irq_en = 1'b1;
            default: ;
        endcase
    endfunction

    function void cpu_tick();
        if (irq_delay != 2'd0)
        begin
            irq_delay = irq_delay - 2'd1;
            if (irq_delay == 2'd0)
                irq_level = 1'b1;
        end
        if (a12_low_seen && a12_low_ticks < bmsi_pkg::A12_TICKS_MAX)
            a12_low_ticks = a12_low_ticks + 4'd1;
        if (cycle_mode || force_tick)
        begin
            prescale = prescale + 2'd1;
            if (prescale == 2'd0)
            begin
                clock_counter(2'd1);
                force_tick = 1'b0;
            end
        end
    endfunction

    function void ppu_access(input logic [15:0] addr);
        bit rising;
        if (cycle_mode)
            return;
        if (addr[12])
        begin
            rising = a12_low_seen && a12_low_ticks >= bmsi_pkg::A12_FILTER;
            a12_low_seen = 1'b0;
            a12_low_ticks = 4'd0;
            if (rising)
                clock_counter(2'd2);
        end
        else if (!a12_low_seen)
        begin
            a12_low_seen = 1'b1;
            a12_low_ticks = 4'd0;
        end
    endfunction

    function bit [8:0] prg_bank(input logic [15:0] addr);
        case (addr[14:13])
            2'd0:    return {1'b0, (bank_sel[6] ? bank_reg[15] : bank_reg[6])};
            2'd1:    return {1'b0, (bank_sel[6] ? bank_reg[6] : bank_reg[7])};
            2'd2:    return {1'b0, (bank_sel[6] ? bank_reg[7] : bank_reg[15])};
            default: return {1'b0, bmsi_pkg::PRG_LAST_BANK};
        endcase
    endfunction

    function bit [8:0] chr_bank(input logic [15:0] addr);
        bit [2:0] slot;
        slot = addr[12:10] ^ {bank_sel[7], 2'b00};
        case (slot)
            3'd0:    return {1'b0, bank_reg[0]};
            3'd1:    return bank_sel[5] ? {1'b0, bank_reg[8]} : {1'b0, bank_reg[0]} + 9'd1;
            3'd2:    return {1'b0, bank_reg[1]};
            3'd3:    return bank_sel[5] ? {1'b0, bank_reg[9]} : {1'b0, bank_reg[1]} + 9'd1;
            3'd4:    return {1'b0, bank_reg[2]};
            3'd5:    return {1'b0, bank_reg[3]};
            3'd6:    return {1'b0, bank_reg[4]};
            default: return {1'b0, bank_reg[5]};
        endcase
    endfunction

    function void note_request(input bmsi_pkg::req_t r);
        bmsi_pkg::rsp_t want;
        want = '0;
        kind_count[r.req_type]++;
        case (r.req_type)
            bmsi_pkg::REQ_WRITE: cpu_write(r.addr, r.value);
            bmsi_pkg::REQ_TICK:  cpu_tick();
            bmsi_pkg::REQ_PPU:   ppu_access(r.addr);
            bmsi_pkg::REQ_PRG:   want.bank = prg_bank(r.addr);
            bmsi_pkg::REQ_CHR:   want.bank = chr_bank(r.addr);
            default: ;
        endcase
        want.irq_line = irq_level;
        want.mirror_horizontal = mirror;
        expected_rsp.push_back(want);
    endfunction

    function void check_response(input bmsi_pkg::rsp_t got);
        bmsi_pkg::rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            $error("response transaction with nothing outstanding: %p", got);
            errors++;
            return;
        end
        want = expected_rsp.pop_front();
        if (got.bank !== want.bank)
        begin
            $error("bank: expected %0d, got %0d", want.bank, got.bank);
            errors++;
        end
        if (got.irq_line !== want.irq_line)
        begin
            $error("irq_line: expected %0b, got %0b", want.irq_line, got.irq_line);
            errors++;
        end
        if (got.mirror_horizontal !== want.mirror_horizontal)
        begin
            $error("mirror_horizontal: expected %0b, got %0b",
                   want.mirror_horizontal, got.mirror_horizontal);
            errors++;
        end
        if (got.irq_line === 1'b1)
            irq_seen++;
    endfunction
endclass

module tb_banked_mapper_with_scanline_irq;

    localparam int          ITEM_TARGET = 1800;
    localparam int          PHASES      = 6;
    localparam int          LONG_HOLD   = 400;
    localparam int          STALL_LIMIT = 4000;
    localparam logic [15:0] PPU_A12     = 16'h1000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    bmsi_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    bmsi_pkg::rsp_t rsp;

    mapper_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    bit hold_request;
    int sent_count;
    int unsigned quiet_cycles;

    banked_mapper_with_scanline_irq dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_banked_mapper_with_scanline_irq: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                rsp_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            if (rx_idle)
            begin
                int gap;
                gap = $urandom_range(0, 19);
                if (gap > 0)
                begin
                    rsp_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            rsp_ready = 1'b1;
            do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_ready));
            @(negedge clk);
        end
    end

    task automatic issue(input logic [2:0] kind, input logic [15:0] addr,
                         input logic [7:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.req_type = kind;
        req.addr = addr;
        req.value = value;
        req_valid = 1'b1;
        do @(posedge clk); while (req_ready !== 1'b1);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic drain_responses();
        req_valid = 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] reg_addr(input logic [15:0] target);
        return (16'($urandom) & ~bmsi_pkg::WR_DECODE_MASK) | target;
    endfunction

    task automatic scanline();
        int n;
        issue(bmsi_pkg::REQ_PPU, 16'($urandom) & ~PPU_A12, 8'($urandom));
        n = $urandom_range(0, 16);
        repeat (n) issue(bmsi_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
        issue(bmsi_pkg::REQ_PPU, 16'($urandom) | PPU_A12, 8'($urandom));
    endtask

    initial
    begin
        int pick;
        int n;
        logic [15:0] target;
        logic [7:0] mode_val;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_request = 1'b0;
        sent_count = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue(bmsi_pkg::REQ_PRG,   16'h0000, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_BANK_SELECT, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_BANK_DATA, 8'hFF);
        issue(bmsi_pkg::REQ_CHR,   16'h0400, 8'h00);
        issue(bmsi_pkg::REQ_CHR,   16'h0000, 8'hFF);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_BANK_SELECT, 8'h06);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_BANK_DATA, 8'h80);
        issue(bmsi_pkg::REQ_PRG,   16'h8000, 8'h00);
        issue(bmsi_pkg::REQ_PRG,   16'hFFFF, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_BANK_SELECT, 8'hEF);
        issue(bmsi_pkg::REQ_WRITE, 16'h9FFF, 8'h5A);
        issue(bmsi_pkg::REQ_PRG,   16'h0000, 8'h00);
        issue(bmsi_pkg::REQ_CHR,   16'hFFFF, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_MIRROR, 8'hFF);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_MIRROR | 16'h0001, 8'hFF);
        issue(bmsi_pkg::REQ_WRITE, 16'h0000, 8'hFF);
        issue(3'd7,                16'hFFFF, 8'hFF);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_RELOAD, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_IRQ_MODE, 8'h01);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_IRQ_ENABLE, 8'h00);
        repeat (5) issue(bmsi_pkg::REQ_TICK, 16'h0000, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_IRQ_DISABLE, 8'h00);
        issue(bmsi_pkg::REQ_WRITE, bmsi_pkg::WR_IRQ_MODE, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            tx_idle = (p % 2 == 1);
            rx_idle = (p % 3 != 0);
            if (p == 2)
                hold_request = 1'b1;
            if (p == 3)
                drain_responses();
            while (sent_count < (p + 1) * ITEM_TARGET / PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    scanline();
                else if (pick < 50)
                begin
                    case ($urandom_range(0, 6))
                        0:       target = bmsi_pkg::WR_BANK_SELECT;
                        1:       target = bmsi_pkg::WR_BANK_DATA;
                        2:       target = bmsi_pkg::WR_MIRROR;
                        3:       target = bmsi_pkg::WR_RELOAD;
                        4:       target = bmsi_pkg::WR_IRQ_MODE;
                        5:       target = bmsi_pkg::WR_IRQ_DISABLE;
                        default: target = bmsi_pkg::WR_IRQ_ENABLE;
                    endcase
                    issue(bmsi_pkg::REQ_WRITE, reg_addr(target), 8'($urandom));
                end
                else if (pick < 60)
                begin
                    mode_val = 8'($urandom);
                    mode_val[0] = ($urandom_range(0, 3) == 0);
                    issue(bmsi_pkg::REQ_WRITE, reg_addr(bmsi_pkg::WR_RELOAD),
                          ($urandom_range(0, 3) == 0) ?
                          8'($urandom) : 8'($urandom_range(0, 4)));
                    issue(bmsi_pkg::REQ_WRITE, reg_addr(bmsi_pkg::WR_IRQ_MODE), mode_val);
                    issue(bmsi_pkg::REQ_WRITE, reg_addr(($urandom_range(0, 4) == 0) ?
                          bmsi_pkg::WR_IRQ_DISABLE : bmsi_pkg::WR_IRQ_ENABLE),
                          8'($urandom));
                end
                else if (pick < 80)
                    issue(($urandom_range(0, 1) == 0) ? bmsi_pkg::REQ_PRG : bmsi_pkg::REQ_CHR,
                          16'($urandom), 8'($urandom));
                else if (pick < 93)
                begin
                    n = $urandom_range(1, 8);
                    repeat (n) issue(bmsi_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
                end
                else
                    issue(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
            end
        end

        drain_responses();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests: %0d writes, %0d ticks, %0d PPU, %0d PRG,",
                 sent_count, sb.kind_count[bmsi_pkg::REQ_WRITE],
                 sb.kind_count[bmsi_pkg::REQ_TICK], sb.kind_count[bmsi_pkg::REQ_PPU],
                 sb.kind_count[bmsi_pkg::REQ_PRG]);
        $display("%0d CHR and %0d unknown; IRQ line high in %0d responses; one %0d-cycle hold-off.",
                 sb.kind_count[bmsi_pkg::REQ_CHR],
                 sb.kind_count[5] + sb.kind_count[6] + sb.kind_count[7],
                 sb.irq_seen, LONG_HOLD);
        if (sb.errors == 0)
            $display("tb_banked_mapper_with_scanline_irq: clean");
        else
            $display("tb_banked_mapper_with_scanline_irq: errors");
        $finish;
    end
endmodule
